@@ rtl/ilie_pkg.sv @@
// Shared types and codes for the indexed list block.
// No dependencies; used by ilie_cell and indexed_list_insert_erase.
`timescale 1ns / 1ps
`default_nettype none

package ilie_pkg;

    // Operation carried in the mode field of an input word.
    typedef enum logic [2:0] {
        MODE_READ     = 3'd0,
        MODE_WRITE    = 3'd1,
        MODE_APPEND   = 3'd2,
        MODE_INSERT   = 3'd3,
        MODE_ERASE    = 3'd4,
        MODE_CLEAR    = 3'd5,
        MODE_FILL     = 3'd6,
        MODE_TRUNCATE = 3'd7
    } mode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    localparam int unsigned DATA_W = 32;

    // Broadcast to every cell: update enable and the operation.
    typedef struct packed {
        logic  en;
        mode_t op;
    } cell_cmd_t;

endpackage

`default_nettype wire

@@ rtl/ilie_cell.sv @@
// One storage cell of the list: a 32-bit word with its update rule.
// Depends on ilie_pkg. Instantiated DEPTH times by indexed_list_insert_erase.
`timescale 1ns / 1ps
`default_nettype none

module ilie_cell #(
    parameter int unsigned POS   = 0,
    parameter int unsigned CNT_W = 7
) (
    input  wire logic                      aclk,
    input  wire ilie_pkg::cell_cmd_t       cmd,
    input  wire logic [CNT_W-1:0]          item_index,
    input  wire logic [CNT_W-1:0]          item_count,
    input  wire logic [ilie_pkg::DATA_W-1:0] item_value,
    input  wire logic [ilie_pkg::DATA_W-1:0] left_data,
    input  wire logic [ilie_pkg::DATA_W-1:0] right_data,
    output logic      [ilie_pkg::DATA_W-1:0] data,
    output logic      [ilie_pkg::DATA_W-1:0] rd_part
);
    import ilie_pkg::*;

    localparam logic [CNT_W-1:0] POS_C  = CNT_W'(POS);
    localparam logic [CNT_W-1:0] POS1_C = CNT_W'(POS + 1);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              at_idx;
    logic              below_idx;
    logic              above_idx;
    logic              at_cnt;
    logic              within_cnt;
    logic              next_in_list;

    assign at_idx       = (POS_C == item_index);
    assign below_idx    = (POS_C < item_index);
    assign above_idx    = (POS_C > item_index);
    assign at_cnt       = (POS_C == item_count);
    assign within_cnt   = (POS_C <= item_count);
    assign next_in_list = (POS1_C < item_count);

    always_comb begin
        data_next = data_reg;
        if (cmd.en) begin
            unique case (cmd.op)
                MODE_WRITE: begin
                    if (at_idx) data_next = item_value;
                end
                MODE_APPEND: begin
                    if (at_cnt) data_next = item_value;
                end
                MODE_INSERT: begin
                    // new word lands at index, tail moves up one
                    if (at_idx) data_next = item_value;
                    else if (above_idx && within_cnt) data_next = left_data;
                end
                MODE_ERASE: begin
                    // tail above index moves down one
                    if (!below_idx && next_in_list) data_next = right_data;
                end
                MODE_FILL: begin
                    if (below_idx) data_next = item_value;
                end
                MODE_READ, MODE_CLEAR, MODE_TRUNCATE: begin
                    data_next = data_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_part = at_idx ? data_reg : '0;

endmodule

`default_nettype wire

@@ rtl/indexed_list_insert_erase.sv @@
// Top level of the indexed list: count register, item checks, cell row, result register.
// Depends on ilie_pkg and ilie_cell.
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit words held in a row of DEPTH
// cells, one word per cell, plus an element count. Every input word carries
// a mode (read, write, append, insert, erase, clear, fill, truncate), an
// index and a value, and yields exactly one result word with the read data,
// the count after the operation, an empty flag and a status (ok, bad index,
// full). A refused operation changes nothing. All cells update in the same
// clock edge: on insert each cell above the index takes its lower neighbor,
// on erase each cell from the index up takes its upper neighbor, so shifts
// complete in the same edge as every other operation. The result is
// written to the output register at the edge that takes the input word; one
// word is accepted per cycle as long as the result register is empty or
// being drained (s_ready follows m_ready when a result is pending). The index
// and count ports are $clog2(DEPTH+1) bits wide. Only cells below the count
// are ever read; cell contents are not cleared at reset.
module indexed_list_insert_erase #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    // input channel
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic [2:0]                              s_mode,
    input  wire logic [$clog2(DEPTH+1)-1:0]              s_index,
    input  wire logic signed [ilie_pkg::DATA_W-1:0]      s_value,
    // result channel
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic signed [ilie_pkg::DATA_W-1:0]           m_read_data,
    output logic      [$clog2(DEPTH+1)-1:0]              m_count,
    output logic                                         m_is_empty,
    output logic      [1:0]                              m_status
);
    import ilie_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // count state
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // result register
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [DATA_W-1:0] rdata_reg;
    logic [CNT_W-1:0]  rcount_reg;
    logic              empty_reg;
    status_t           status_reg;

    logic              accept;
    mode_t             op;
    status_t           status;
    logic              idx_in_list;
    logic              list_full;
    logic [CNT_W-1:0]  new_count;
    logic [DATA_W-1:0] rd_or;
    logic [DATA_W-1:0] rd_word;
    cell_cmd_t         cmd;

    // cell row wiring
    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DATA_W-1:0] cell_rd   [DEPTH];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign op      = mode_t'(s_mode);

    assign idx_in_list = (s_index < count_reg);
    assign list_full   = (count_reg == DEPTH_C);

    // check the word against the current count
    always_comb begin
        status = ST_OK;
        unique case (op)
            MODE_READ, MODE_WRITE, MODE_ERASE: begin
                if (!idx_in_list) status = ST_BAD_INDEX;
            end
            MODE_APPEND: begin
                if (list_full) status = ST_FULL;
            end
            MODE_INSERT: begin
                // index is checked before fullness
                if (s_index > count_reg) status = ST_BAD_INDEX;
                else if (list_full)      status = ST_FULL;
            end
            MODE_FILL: begin
                if (s_index > DEPTH_C) status = ST_FULL;
            end
            MODE_CLEAR, MODE_TRUNCATE: begin
                status = ST_OK;
            end
        endcase
    end

    always_comb begin
        new_count = count_reg;
        unique case (op)
            MODE_APPEND, MODE_INSERT: new_count = count_reg + CNT_W'(1);
            MODE_ERASE:               new_count = count_reg - CNT_W'(1);
            MODE_CLEAR:               new_count = '0;
            MODE_FILL:                new_count = s_index;
            MODE_TRUNCATE:            new_count = idx_in_list ? s_index : count_reg;
            MODE_READ, MODE_WRITE:    new_count = count_reg;
        endcase
    end

    assign count_next = (accept && status == ST_OK) ? new_count : count_reg;

    assign cmd.en = accept && (status == ST_OK);
    assign cmd.op = op;

    // row of cells, each wired to its two neighbors
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;

        // bottom cell never shifts up, top cell never shifts down
        if (i == 0) begin : g_lo
            assign left_w = cell_data[i];
        end else begin : g_lo_n
            assign left_w = cell_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_hi
            assign right_w = cell_data[i];
        end else begin : g_hi_n
            assign right_w = cell_data[i+1];
        end

        ilie_cell #(
            .POS   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .item_index (s_index),
            .item_count (count_reg),
            .item_value (s_value),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i]),
            .rd_part    (cell_rd[i])
        );
    end

    // only the addressed cell drives a nonzero read part
    always_comb begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    assign rd_word = (op == MODE_READ && status == ST_OK) ? rd_or : '0;

    assign m_valid_next = accept ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rdata_reg  <= rd_word;
            rcount_reg <= count_next;
            empty_reg  <= (count_next == '0);
            status_reg <= status;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = rdata_reg;
    assign m_count     = rcount_reg;
    assign m_is_empty  = empty_reg;
    assign m_status    = status_reg;

endmodule

`default_nettype wire

@@ test/tb_indexed_list_insert_erase.sv @@
// Self-checking testbench for indexed_list_insert_erase: directed table, then random words.
// Depends on ilie_pkg and the indexed_list_insert_erase RTL; needs no other file.
`timescale 1ns / 1ps

module tb_indexed_list_insert_erase;
    import ilie_pkg::*;

    localparam int unsigned DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH + 1);
    localparam int SLOT_W = $clog2(DEPTH);

    localparam int RANDOM_WORDS = 2000;
    localparam int HOLD_AT_WORD = 300;    // receiver holds off here
    localparam int DRAIN_AT_WORD = 1000;  // sender pauses until all results are back
    localparam int STEADY_FROM = 1400;    // no idling on either side in this window
    localparam int STEADY_TO = 1600;
    localparam int LONG_HOLD = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTS = 40;

    typedef struct {
        logic signed [DATA_W-1:0] read_data;
        logic [IDX_W-1:0]         count;
        logic                     is_empty;
        status_t                  status;
    } list_result_t;

    // One row of the directed table; want is only used when typed is set.
    typedef struct {
        mode_t                    op;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] val;
        bit                       typed;
        list_result_t             want;
    } list_step_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [2:0]               s_mode;
    logic [IDX_W-1:0]         s_index;
    logic signed [DATA_W-1:0] s_value;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_read_data;
    logic [IDX_W-1:0]         m_count;
    logic                     m_is_empty;
    logic [1:0]               m_status;

    // Shadow copy of the list contents and length.
    logic signed [DATA_W-1:0] shadow_words [DEPTH];
    int unsigned              shadow_len = 0;

    list_result_t pending_results [$];
    list_step_t   directed_rows [$];
    list_result_t oldest;

    int  mismatch_count = 0;
    int  results_seen = 0;
    int  run_cycles;
    bit  hold_req = 1'b0;
    bit  steady = 1'b0;

    indexed_list_insert_erase #(
        .DEPTH(DEPTH)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mode     (s_mode),
        .s_index    (s_index),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_read_data(m_read_data),
        .m_count    (m_count),
        .m_is_empty (m_is_empty),
        .m_status   (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Applies one word to the shadow list and returns the result it gives.
    // Refused words leave the shadow untouched.
    function automatic list_result_t apply_list_op(mode_t op, int unsigned idx,
                                                   logic signed [DATA_W-1:0] val);
        list_result_t r;
        int unsigned i;
        r.read_data = '0;
        r.status = ST_OK;
        case (op)
            MODE_READ: begin
                if (idx < shadow_len) r.read_data = shadow_words[SLOT_W'(idx)];
                else r.status = ST_BAD_INDEX;
            end
            MODE_WRITE: begin
                if (idx < shadow_len) shadow_words[SLOT_W'(idx)] = val;
                else r.status = ST_BAD_INDEX;
            end
            MODE_APPEND: begin
                if (shadow_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_words[SLOT_W'(shadow_len)] = val;
                    shadow_len++;
                end
            end
            MODE_INSERT: begin
                // index is checked before fullness
                if (idx > shadow_len) begin
                    r.status = ST_BAD_INDEX;
                end else if (shadow_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = shadow_len; i > idx; i--)
                        shadow_words[SLOT_W'(i)] = shadow_words[SLOT_W'(i - 1)];
                    shadow_words[SLOT_W'(idx)] = val;
                    shadow_len++;
                end
            end
            MODE_ERASE: begin
                if (idx >= shadow_len) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    for (i = idx; i + 1 < shadow_len; i++)
                        shadow_words[SLOT_W'(i)] = shadow_words[SLOT_W'(i + 1)];
                    shadow_len--;
                end
            end
            MODE_CLEAR: shadow_len = 0;
            MODE_FILL: begin
                if (idx > DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = 0; i < idx; i++) shadow_words[SLOT_W'(i)] = val;
                    shadow_len = idx;
                end
            end
            MODE_TRUNCATE: begin
                // growing via truncate is a no-op
                if (idx < shadow_len) shadow_len = idx;
            end
            default: ;
        endcase
        r.count = shadow_len[IDX_W-1:0];
        r.is_empty = (shadow_len == 0);
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_step(mode_t op, int idx, logic signed [DATA_W-1:0] val,
                                     bit typed, logic signed [DATA_W-1:0] rd, int cnt,
                                     status_t st);
        list_step_t row;
        row.op = op;
        row.idx = idx[IDX_W-1:0];
        row.val = val;
        row.typed = typed;
        row.want.read_data = rd;
        row.want.count = cnt[IDX_W-1:0];
        row.want.is_empty = (cnt == 0);
        row.want.status = st;
        directed_rows.push_back(row);
    endfunction

    task automatic flag_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t: result %0d, %s: got %h, want %h", $time, results_seen, what,
                     got, want);
        mismatch_count++;
    endtask

    // Offers one word after gap idle cycles, holds it until taken, then
    // records what the block should answer.
    task automatic send_word(mode_t op, logic [IDX_W-1:0] idx, logic signed [DATA_W-1:0] val,
                             int gap, bit typed, list_result_t typed_want);
        list_result_t predicted;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_mode <= op;
        s_index <= idx;
        s_value <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = apply_list_op(op, 32'(idx), val);
        pending_results.push_back(typed ? typed_want : predicted);
    endtask

    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Receiver: random stalls, one long hold-off on request, none in the steady window.
    initial begin : receiver
        int stall;
        int hold_cycles;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++)
                    @(negedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else begin
                stall = steady ? 0 : pick_gap();
                if (stall != 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
                m_ready <= 1'b1;
            end
        end
    end

    // Result checker: every taken word against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                flag_mismatch("word with nothing expected", m_read_data, '0);
            end else begin
                oldest = pending_results.pop_front();
                if (m_read_data !== oldest.read_data)
                    flag_mismatch("read_data", m_read_data, oldest.read_data);
                if (m_count !== oldest.count)
                    flag_mismatch("count", DATA_W'(m_count), DATA_W'(oldest.count));
                if (m_is_empty !== oldest.is_empty)
                    flag_mismatch("is_empty", DATA_W'(m_is_empty), DATA_W'(oldest.is_empty));
                if (m_status !== oldest.status)
                    flag_mismatch("status", DATA_W'(m_status), DATA_W'(oldest.status));
            end
        end
    end

    // Watchdog.
    initial begin
        run_cycles = 0;
        while (run_cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            run_cycles++;
        end
        $display("indexed_list_insert_erase regression: fail");
        $finish;
    end

    initial begin : stimulus
        list_step_t               row;
        list_result_t             unused_want;
        mode_t                    op;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] val;
        int                       pick;
        int                       n;

        s_valid = 1'b0;
        s_mode = '0;
        s_index = '0;
        s_value = '0;
        unused_want = '{default: '0, status: ST_OK};
        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table: typed results where obvious, predictor elsewhere.
        //       op             idx  value           typed rd              cnt status
        add_step(MODE_READ,     0,   32'sd0,         1, 32'sd0,          0,  ST_BAD_INDEX);
        add_step(MODE_ERASE,    0,   32'sd0,         1, 32'sd0,          0,  ST_BAD_INDEX);
        add_step(MODE_WRITE,    0,   32'sd17,        1, 32'sd0,          0,  ST_BAD_INDEX);
        add_step(MODE_TRUNCATE, 5,   32'sd0,         1, 32'sd0,          0,  ST_OK);
        add_step(MODE_APPEND,   0,   32'sh7FFF_FFFF, 1, 32'sd0,          1,  ST_OK);
        add_step(MODE_APPEND,   0,   32'sh8000_0000, 1, 32'sd0,          2,  ST_OK);
        add_step(MODE_READ,     0,   32'sd0,         1, 32'sh7FFF_FFFF,  2,  ST_OK);
        add_step(MODE_READ,     1,   32'sd0,         1, 32'sh8000_0000,  2,  ST_OK);
        // insert past the end is refused, at the end it appends
        add_step(MODE_INSERT,   3,   32'sd5,         1, 32'sd0,          2,  ST_BAD_INDEX);
        add_step(MODE_INSERT,   0,   -32'sd1,        0, 32'sd0,          0,  ST_OK);
        add_step(MODE_INSERT,   3,   32'sd5,         0, 32'sd0,          0,  ST_OK);
        add_step(MODE_ERASE,    1,   32'sd0,         0, 32'sd0,          0,  ST_OK);
        add_step(MODE_WRITE,    2,   32'sd0,         0, 32'sd0,          0,  ST_OK);
        add_step(MODE_READ,     2,   32'sd0,         0, 32'sd0,          0,  ST_OK);
        // fill beyond capacity, then to capacity
        add_step(MODE_FILL,     65,  32'sd9,         1, 32'sd0,          3,  ST_FULL);
        add_step(MODE_FILL,     64,  32'sh5555_AAAA, 1, 32'sd0,          64, ST_OK);
        add_step(MODE_APPEND,   0,   32'sd1,         1, 32'sd0,          64, ST_FULL);
        add_step(MODE_INSERT,   64,  32'sd2,         1, 32'sd0,          64, ST_FULL);
        add_step(MODE_INSERT,   0,   32'sd3,         1, 32'sd0,          64, ST_FULL);
        add_step(MODE_WRITE,    63,  32'shAAAA_5555, 0, 32'sd0,          0,  ST_OK);
        add_step(MODE_READ,     63,  32'sd0,         1, 32'shAAAA_5555,  64, ST_OK);
        add_step(MODE_READ,     64,  32'sd0,         1, 32'sd0,          64, ST_BAD_INDEX);
        add_step(MODE_ERASE,    63,  32'sd0,         1, 32'sd0,          63, ST_OK);
        add_step(MODE_TRUNCATE, 64,  32'sd0,         1, 32'sd0,          63, ST_OK);
        add_step(MODE_TRUNCATE, 10,  32'sd0,         1, 32'sd0,          10, ST_OK);
        add_step(MODE_CLEAR,    0,   32'sd0,         1, 32'sd0,          0,  ST_OK);
        add_step(MODE_FILL,     0,   32'sd4,         1, 32'sd0,          0,  ST_OK);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_word(row.op, row.idx, row.val, pick_gap(), row.typed, row.want);
        end

        // Random part: mostly in-range indexes so the list grows, shifts and fills.
        for (n = 0; n < RANDOM_WORDS; n++) begin
            if (n == HOLD_AT_WORD) hold_req = 1'b1;   // sender keeps offering meanwhile
            if (n == DRAIN_AT_WORD) wait_results_drained();
            steady = (n >= STEADY_FROM && n < STEADY_TO);

            pick = $urandom_range(0, 99);
            if (pick < 18) op = MODE_READ;
            else if (pick < 32) op = MODE_WRITE;
            else if (pick < 46) op = MODE_APPEND;
            else if (pick < 62) op = MODE_INSERT;
            else if (pick < 78) op = MODE_ERASE;
            else if (pick < 80) op = MODE_CLEAR;
            else if (pick < 88) op = MODE_FILL;
            else op = MODE_TRUNCATE;

            case (op)
                MODE_READ, MODE_WRITE, MODE_ERASE: begin
                    if (shadow_len == 0) idx = '0;
                    else idx = IDX_W'($urandom_range(0, shadow_len - 1));
                end
                MODE_INSERT: idx = IDX_W'($urandom_range(0, shadow_len));
                MODE_FILL: begin
                    // half of the fills land near capacity
                    if ($urandom_range(0, 1) != 0) idx = IDX_W'($urandom_range(0, DEPTH));
                    else idx = IDX_W'($urandom_range(DEPTH - 8, DEPTH));
                end
                default: idx = IDX_W'($urandom_range(0, DEPTH));
            endcase
            if ($urandom_range(0, 99) < 15) idx = IDX_W'($urandom_range(0, DEPTH));

            val = $urandom;
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0: val = 32'sd0;
                    1: val = -32'sd1;
                    2: val = 32'sh7FFF_FFFF;
                    default: val = 32'sh8000_0000;
                endcase
            end

            send_word(op, idx, val, steady ? 0 : pick_gap(), 1'b0, unused_want);
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("indexed_list_insert_erase regression: pass");
        end else begin
            $display("indexed_list_insert_erase regression: fail");
        end
        $finish;
    end

endmodule
